// ===== hw/rtl/partitioned_fifo_queue_top_macros.svh =====
// Assertion macros for the partitioned FIFO queue.
`ifndef PARTITIONED_FIFO_QUEUE_TOP_MACROS_SVH
`define PARTITIONED_FIFO_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PFQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pfq assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define PFQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pfq assertion failed");

`endif

// ===== hw/rtl/pfq_pkg.sv =====
// Shared types, codes and defaults of the partitioned FIFO queue.
package pfq_pkg;

    localparam int DEF_MAX_PARTITIONS = 8;
    localparam int DEF_SLOT_COUNT     = 256;
    localparam int DEF_WORD_WIDTH     = 32;

    localparam int MODE_W       = 1;
    localparam int PART_FIELD_W = 3;
    localparam int WORD_FIELD_W = 32;
    localparam int STATUS_W     = 2;
    localparam int CFG_W        = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic [MODE_W-1:0] MODE_ENQ = 1'b0;
    localparam logic [MODE_W-1:0] MODE_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PART = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// ===== hw/rtl/pfq_if.sv =====
// Request and response word channels of the partitioned FIFO queue.
interface pfq_req_if;
    import pfq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [PART_FIELD_W-1:0] partition;
    logic [WORD_FIELD_W-1:0] write_word;

    modport source (output valid, mode, partition, write_word, input ready);
    modport sink   (input valid, mode, partition, write_word, output ready);
endinterface

interface pfq_rsp_if;
    import pfq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [WORD_FIELD_W-1:0] read_word;

    modport source (output valid, status, read_word, input ready);
    modport sink   (input valid, status, read_word, output ready);
endinterface

// ===== hw/rtl/pfq_ram.sv =====
// Simple dual-port RAM with registered read, one write and one read per cycle.
module pfq_ram #(
    parameter int DEPTH = pfq_pkg::DEF_SLOT_COUNT,
    parameter int WIDTH = pfq_pkg::DEF_WORD_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hw/rtl/partitioned_fifo_queue_top.sv =====
// Top level of the partitioned FIFO queue: control, queue registers and slot RAMs.
//
// Several FIFO queues share one store of SLOT_COUNT slots kept as linked lists.
// i_req carries one request word: mode (enqueue or dequeue), partition and
// write_word. o_rsp returns one response word per request: status and read_word.
// i_cfg_we with i_cfg_wdata writes partitions_in_use; write it only while idle.
// In the accept cycle a request reads the link and payload RAMs; the execute
// state then uses the read data, writes back and loads the output register.
// The response is valid the cycle after that; a new request is accepted only
// after the last one leaves the execute state, since the slot RAMs read registered.
// If the receiver stalls, the finished response holds in the output register
// and the block still accepts one more request; that request waits in the
// execute state until the output register frees, with i_req.ready low.
// Reset empties all queues and the free list and sets partitions_in_use to 8;
// slots are handed out fresh in order, so no RAM clearing pass is needed.
`include "partitioned_fifo_queue_top_macros.svh"

module partitioned_fifo_queue_top #(
    parameter int MAX_PARTITIONS = pfq_pkg::DEF_MAX_PARTITIONS,
    parameter int SLOT_COUNT     = pfq_pkg::DEF_SLOT_COUNT,
    parameter int WORD_WIDTH     = pfq_pkg::DEF_WORD_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pfq_pkg::CFG_W-1:0] i_cfg_wdata,
    pfq_req_if.sink                   i_req,
    pfq_rsp_if.source                 o_rsp
);
    import pfq_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int PART_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int IDX_W  = (PART_W > PART_FIELD_W) ? PART_W : PART_FIELD_W;
    localparam int CPY_W  = (WORD_WIDTH < WORD_FIELD_W) ? WORD_WIDTH : WORD_FIELD_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_parts;
    logic [SLOT_W-1:0] r_head [MAX_PARTITIONS];
    logic [SLOT_W-1:0] r_tail [MAX_PARTITIONS];
    logic [CNT_W-1:0]  r_len  [MAX_PARTITIONS];
    logic [SLOT_W-1:0] r_free_head;
    logic [CNT_W-1:0]  r_free_count;
    logic [CNT_W-1:0]  r_fresh;

    logic [MODE_W-1:0]   r_op;
    logic [PART_W-1:0]   r_pidx;
    logic [WORD_WIDTH-1:0] r_word;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_from_free;

    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic [WORD_FIELD_W-1:0] r_out_word;

    logic                  accept;
    logic                  fire;
    logic                  exec_ok;
    logic [IDX_W-1:0]      p_ext;
    logic [PART_W-1:0]     p_idx;
    logic                  part_ok;
    logic                  store_full;
    logic [STATUS_W-1:0]   dec_status;
    logic [SLOT_W-1:0]     alloc_slot;
    logic [WORD_WIDTH-1:0] in_word;
    logic [WORD_FIELD_W-1:0] out_word;

    logic              link_wr_en;
    logic [SLOT_W-1:0] link_wr_addr;
    logic [SLOT_W-1:0] link_wr_data;
    logic [SLOT_W-1:0] link_rd_addr;
    logic [SLOT_W-1:0] link_rd_data;
    logic              pay_wr_en;
    logic [WORD_WIDTH-1:0] pay_rd_data;

    // Request decode in the accept cycle.
    always_comb begin
        p_ext      = IDX_W'(i_req.partition);
        p_idx      = p_ext[PART_W-1:0];
        part_ok    = ({1'b0, i_req.partition} < r_parts) &&
                     (32'(i_req.partition) < MAX_PARTITIONS);
        store_full = (r_free_count == '0) && (r_fresh == CNT_W'(SLOT_COUNT));
        alloc_slot = (r_free_count != '0) ? r_free_head : r_fresh[SLOT_W-1:0];
        in_word    = '0;
        in_word[CPY_W-1:0] = i_req.write_word[CPY_W-1:0];
        priority if (!part_ok) begin
            dec_status = STATUS_BAD_PART;
        end else if (i_req.mode == MODE_ENQ) begin
            dec_status = store_full ? STATUS_FULL : STATUS_OK;
        end else begin
            dec_status = (r_len[p_idx] == '0) ? STATUS_EMPTY : STATUS_OK;
        end
        link_rd_addr = (i_req.mode == MODE_ENQ) ? r_free_head : r_head[p_idx];
    end

    assign accept  = i_req.valid && i_req.ready;
    assign fire    = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);
    assign exec_ok = fire && (r_status == STATUS_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Write-back of the slot RAMs in the execute cycle.
    always_comb begin
        pay_wr_en    = exec_ok && (r_op == MODE_ENQ);
        link_wr_en   = 1'b0;
        link_wr_addr = r_slot;
        link_wr_data = r_free_head;
        if (exec_ok) begin
            if (r_op == MODE_ENQ) begin
                link_wr_en   = (r_len[r_pidx] != '0);
                link_wr_addr = r_tail[r_pidx];
                link_wr_data = r_slot;
            end else begin
                link_wr_en   = (r_free_count != '0);
            end
        end
        out_word = '0;
        if (r_status == STATUS_OK && r_op == MODE_DEQ) begin
            out_word[CPY_W-1:0] = pay_rd_data[CPY_W-1:0];
        end
    end

    pfq_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (SLOT_W)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (link_wr_addr),
        .i_wr_data (link_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (link_rd_addr),
        .o_rd_data (link_rd_data)
    );

    pfq_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (WORD_WIDTH)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pay_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_word),
        .i_rd_en   (accept),
        .i_rd_addr (r_head[p_idx]),
        .o_rd_data (pay_rd_data)
    );

    // Control state: config, lengths, free list, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parts      <= CFG_RESET;
            r_free_head  <= '0;
            r_free_count <= '0;
            r_fresh      <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < MAX_PARTITIONS; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_parts <= i_cfg_wdata;
            end
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end
            if (exec_ok) begin
                if (r_op == MODE_ENQ) begin
                    r_len[r_pidx] <= r_len[r_pidx] + 1'b1;
                    if (r_from_free) begin
                        r_free_count <= r_free_count - 1'b1;
                        if (r_free_count > CNT_W'(1)) begin
                            r_free_head <= link_rd_data;
                        end
                    end else begin
                        r_fresh <= r_fresh + 1'b1;
                    end
                end else begin
                    r_len[r_pidx] <= r_len[r_pidx] - 1'b1;
                    r_free_head   <= r_slot;
                    r_free_count  <= r_free_count + 1'b1;
                end
            end
        end
    end

    // Payload state: heads, tails, the latched request and the output word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= i_req.mode;
            r_pidx      <= p_idx;
            r_word      <= in_word;
            r_status    <= dec_status;
            r_slot      <= (i_req.mode == MODE_ENQ) ? alloc_slot : r_head[p_idx];
            r_from_free <= (r_free_count != '0);
        end
        if (exec_ok) begin
            if (r_op == MODE_ENQ) begin
                if (r_len[r_pidx] == '0) begin
                    r_head[r_pidx] <= r_slot;
                end
                r_tail[r_pidx] <= r_slot;
            end else if (r_len[r_pidx] > CNT_W'(1)) begin
                r_head[r_pidx] <= link_rd_data;
            end
        end
        if (fire) begin
            r_out_status <= r_status;
            r_out_word   <= out_word;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.read_word = r_out_word;

    `PFQ_ASSERT_NEXT(a_accept_to_exec, accept, r_state == ST_EXEC)
    `PFQ_ASSERT_SAME(a_free_within_used, 1'b1, r_free_count <= r_fresh)
    `PFQ_ASSERT_SAME(a_fresh_bounded, 1'b1, r_fresh <= CNT_W'(SLOT_COUNT))
    `PFQ_ASSERT_SAME(a_fail_word_zero, r_out_valid && r_out_status != STATUS_OK,
                     r_out_word == '0)
endmodule
